// File: rtl/iis_pkg.sv
`timescale 1ns / 1ps
package iis_pkg;

    localparam int PIX_W  = 16;
    localparam int COL_W  = 16;
    localparam int ROW_W  = 24;
    localparam int N_W    = 25;
    localparam int SUM_W  = 41;
    localparam int SQ_W   = 55;
    localparam int CW_W   = 57;
    localparam int RW_W   = 64;
    localparam int FIX_W  = 24;
    localparam int OUT_TDATA_W = 328;

    localparam logic [COL_W-1:0] WIDTH_RESET = 16'd512;

    // Totals of one finished image, handed from the front to the back.
    typedef struct packed {
        logic signed [PIX_W-1:0] min_value;
        logic signed [PIX_W-1:0] max_value;
        logic [SUM_W-1:0]        sum;
        logic [SQ_W-1:0]         sq;
        logic [CW_W-1:0]         cw;
        logic [RW_W-1:0]         rw;
        logic [N_W-1:0]          n;
    } snap_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MEAN,
        BK_MULA,
        BK_MULB,
        BK_MULD,
        BK_VDIV,
        BK_SQRT,
        BK_DONE
    } bk_state_t;

endpackage

// File: rtl/iis_front.sv
`timescale 1ns / 1ps
module iis_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] pixel_value
    input  logic                s_tlast,   // last_pixel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,  // image_width
    input  logic                q_full,
    output logic                q_push,
    output iis_pkg::snap_t      q_data
);

    logic [iis_pkg::COL_W-1:0]        width_reg;
    logic [iis_pkg::COL_W-1:0]        col_reg, col_next;
    logic [iis_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [iis_pkg::N_W-1:0]          cnt_reg, cnt_next;
    logic [iis_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [iis_pkg::SQ_W-1:0]         sq_reg, sq_next;
    logic [iis_pkg::CW_W-1:0]         cw_reg, cw_next;
    logic [iis_pkg::RW_W-1:0]         rw_reg, rw_next;
    logic signed [iis_pkg::PIX_W-1:0] min_reg, min_next, max_reg, max_next;
    logic signed [iis_pkg::PIX_W-1:0] pix;
    logic signed [31:0]               sq_prod;
    logic signed [32:0]               cw_prod;
    logic signed [40:0]               rw_prod;
    logic [iis_pkg::COL_W-1:0]        col_inc;
    logic                             take;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign take      = s_tvalid && s_tready;
    assign q_push    = take && s_tlast;

    always_comb begin
        pix      = $signed(s_tdata);
        sq_prod  = pix * pix;
        cw_prod  = pix * $signed({1'b0, col_reg});
        rw_prod  = pix * $signed({1'b0, row_reg});
        min_next = (cnt_reg == '0 || pix < min_reg) ? pix : min_reg;
        max_next = (cnt_reg == '0 || pix > max_reg) ? pix : max_reg;
        sum_next = sum_reg + {{(iis_pkg::SUM_W-16){pix[15]}}, pix};
        sq_next  = sq_reg + {{(iis_pkg::SQ_W-32){1'b0}}, sq_prod};
        cw_next  = cw_reg + {{(iis_pkg::CW_W-33){cw_prod[32]}}, cw_prod};
        rw_next  = rw_reg + {{(iis_pkg::RW_W-41){rw_prod[40]}}, rw_prod};
        cnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        col_inc  = col_reg + 1'b1;
        if (col_inc == width_reg) begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end else begin
            col_next = col_inc;
            row_next = row_reg;
        end
        q_data = '{min_value: min_next, max_value: max_next, sum: sum_next, sq: sq_next,
                   cw: cw_next, rw: rw_next, n: cnt_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= iis_pkg::WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            cw_reg  <= '0;
            rw_reg  <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end else if (take) begin
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
            cw_reg  <= cw_next;
            rw_reg  <= rw_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

// File: rtl/iis_queue.sv
`timescale 1ns / 1ps
module iis_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  iis_pkg::snap_t push_data,
    output logic           full,
    output logic           valid,
    input  logic           pop,
    output iis_pkg::snap_t pop_data
);

    iis_pkg::snap_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign valid    = (fill_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      fill_reg <= fill_reg + 2'd1;
            else if (pop && !push) fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

// File: rtl/iis_back.sv
`timescale 1ns / 1ps
module iis_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  iis_pkg::snap_t q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [iis_pkg::OUT_TDATA_W-1:0] m_tdata
);

    iis_pkg::bk_state_t state_reg, state_next;
    iis_pkg::snap_t     snap_reg, snap_next;
    logic [80:0]  prod_reg, prod_next, mc_reg, mc_next, a_reg, a_next, prod_add;
    logic [40:0]  mb_reg, mb_next, mag;
    logic [95:0]  num_reg, num_next;
    logic [49:0]  d_reg, d_next;
    logic [50:0]  rem_reg, rem_next, remt, srt, trial;
    logic [48:0]  quo_reg, quo_next, quo_div;
    logic         ovf_reg, ovf_next, ge, ge2;
    logic [6:0]   cnt_reg, cnt_next;
    logic [23:0]  mean_reg, mean_next, dev_next, root_new;
    logic         out_valid_reg, out_valid_next;
    logic [iis_pkg::OUT_TDATA_W-1:0] out_reg, out_next;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        state_next     = state_reg;
        snap_next      = snap_reg;
        prod_next      = prod_reg;
        mc_next        = mc_reg;
        mb_next        = mb_reg;
        a_next         = a_reg;
        num_next       = num_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        dev_next       = '0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;

        mag = snap_reg.sum[40] ? 41'(-snap_reg.sum) : snap_reg.sum;

        // shared shift-add multiplier step
        prod_add = mb_reg[0] ? prod_reg + mc_reg : prod_reg;
        // shared restoring divider step
        remt    = {rem_reg[49:0], num_reg[95]};
        ge      = (remt >= {1'b0, d_reg});
        quo_div = {quo_reg[47:0], ge};
        // square root step, two radicand bits a cycle
        srt      = {rem_reg[48:0], num_reg[95:94]};
        trial    = {25'd0, quo_reg[23:0], 2'b01};
        ge2      = (srt >= trial);
        root_new = {quo_reg[22:0], ge2};

        case (state_reg)
            iis_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    snap_next  = q_data;
                    state_next = iis_pkg::BK_MEAN;
                    rem_next   = '0;
                    quo_next   = '0;
                    d_next     = {25'd0, q_data.n};
                    cnt_next   = 7'd49;
                    num_next   = {(q_data.sum[40] ? 41'(-q_data.sum) : q_data.sum), 8'd0, 47'd0};
                end
            end
            iis_pkg::BK_MEAN: begin
                num_next = {num_reg[94:0], 1'b0};
                rem_next = ge ? remt - {1'b0, d_reg} : remt;
                quo_next = quo_div;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    if (!snap_reg.sum[40]) begin
                        mean_next = (quo_div > 49'd8388607) ? 24'h7FFFFF : quo_div[23:0];
                    end else begin
                        mean_next = (quo_div > 49'd8388608) ? 24'h800000
                                                            : (~quo_div[23:0]) + 24'd1;
                    end
                    if (snap_reg.n < 25'd2) begin
                        state_next = iis_pkg::BK_DONE;
                    end else begin
                        state_next = iis_pkg::BK_MULA;
                        prod_next  = '0;
                        mc_next    = {26'd0, snap_reg.sq};
                        mb_next    = {16'd0, snap_reg.n};
                        cnt_next   = 7'd25;
                    end
                end
            end
            iis_pkg::BK_MULA, iis_pkg::BK_MULB, iis_pkg::BK_MULD: begin
                prod_next = prod_add;
                mc_next   = {mc_reg[79:0], 1'b0};
                mb_next   = {1'b0, mb_reg[40:1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    prod_next = '0;
                    if (state_reg == iis_pkg::BK_MULA) begin
                        a_next     = prod_add;
                        mc_next    = {40'd0, mag};
                        mb_next    = mag;
                        cnt_next   = 7'd41;
                        state_next = iis_pkg::BK_MULB;
                    end else if (state_reg == iis_pkg::BK_MULB) begin
                        if (a_reg < prod_add) begin
                            // hold the square of the sum so the done state sees a < b
                            prod_next  = prod_add;
                            state_next = iis_pkg::BK_DONE;
                        end else begin
                            num_next   = {80'(a_reg - prod_add), 16'd0};
                            mc_next    = {56'd0, snap_reg.n};
                            mb_next    = {16'd0, snap_reg.n - 1'b1};
                            cnt_next   = 7'd25;
                            state_next = iis_pkg::BK_MULD;
                        end
                    end else begin
                        d_next     = prod_add[49:0];
                        rem_next   = '0;
                        quo_next   = '0;
                        ovf_next   = 1'b0;
                        cnt_next   = 7'd96;
                        state_next = iis_pkg::BK_VDIV;
                    end
                end
            end
            iis_pkg::BK_VDIV: begin
                num_next = {num_reg[94:0], 1'b0};
                rem_next = ge ? remt - {1'b0, d_reg} : remt;
                quo_next = quo_div;
                ovf_next = ovf_reg | quo_reg[47];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    if (ovf_reg | quo_reg[47]) begin
                        state_next = iis_pkg::BK_DONE;
                    end else begin
                        num_next   = {quo_div[47:0], 48'd0};
                        rem_next   = '0;
                        quo_next   = '0;
                        cnt_next   = 7'd24;
                        state_next = iis_pkg::BK_SQRT;
                    end
                end
            end
            iis_pkg::BK_SQRT: begin
                num_next = {num_reg[93:0], 2'b00};
                rem_next = ge2 ? srt - trial : srt;
                quo_next = {25'd0, root_new};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    state_next = iis_pkg::BK_DONE;
                end
            end
            iis_pkg::BK_DONE: begin
                // pick the deviation by how the run ended
                if (snap_reg.n < 25'd2 || a_reg < prod_reg) begin
                    dev_next = '0;
                end else if (ovf_reg) begin
                    dev_next = 24'hFFFFFF;
                end else begin
                    dev_next = quo_reg[23:0];
                end
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_next = {6'd0, dev_next, mean_next, snap_reg.n, snap_reg.rw, snap_reg.cw,
                                snap_reg.sq, snap_reg.sum, snap_reg.max_value,
                                snap_reg.min_value};
                    state_next = iis_pkg::BK_IDLE;
                end
            end
            default: state_next = iis_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= iis_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
        prod_reg <= prod_next;
        mc_reg   <= mc_next;
        mb_reg   <= mb_next;
        a_reg    <= a_next;
        num_reg  <= num_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        ovf_reg  <= ovf_next;
        cnt_reg  <= cnt_next;
        mean_reg <= mean_next;
        out_reg  <= out_next;
    end

    a_iter_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == iis_pkg::BK_MEAN || state_reg == iis_pkg::BK_VDIV ||
         state_reg == iis_pkg::BK_SQRT || state_reg == iis_pkg::BK_MULA)
        |-> cnt_reg != 7'd0)
        else $error("iteration counter ran out inside a step state");

    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $signed(out_reg[15:0]) <= $signed(out_reg[31:16]))
        else $error("min above max in result");

    a_single_dev: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg[273:249] == 25'd1) |-> out_reg[321:298] == 24'd0)
        else $error("nonzero deviation for a one-pixel image");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == iis_pkg::BK_MEAN)
        else $error("pop did not start the mean division");

endmodule

// File: rtl/image_intensity_statistics_core.sv
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// s_       | in        | s_tvalid / s_tready  | s_tdata pixel_value, s_tlast last_pixel
// m_       | out       | m_tvalid / m_tready  | m_tdata all nine statistics
// cfg_     | in        | cfg_valid/cfg_ready  | cfg_data image_width
//
// Pixels are taken one per cycle; the front stalls only when two finished
// images already wait in the queue for the back end.
// The back end finishes one image before it pops the next: a pop, the mean-divide
// steps, the shift-add multiply steps, the variance-divide steps, the root steps,
// then the output; a one-pixel image goes from the mean division straight to output.
// aresetn is synchronous, active low; it sets image_width to 512.
// A pending result holds on m_tdata until m_tready takes it.
module image_intensity_statistics_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] pixel_value
    input  logic         s_tlast,   // last_pixel
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] min_value, [31:16] max_value, [72:32] intensity_sum,
    // [127:73] square_sum, [184:128] column_weighted_sum,
    // [248:185] row_weighted_sum, [273:249] pixel_total,
    // [297:274] mean_fixed, [321:298] deviation_fixed, [327:322] zero
    output logic [327:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // image_width
);

    // hand-off between the accumulating front and the finishing back end
    logic           q_push, q_full, q_valid, q_pop;
    iis_pkg::snap_t q_in, q_out;

    // accumulate per pixel; snapshot totals on the last pixel
    iis_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // hold up to two finished images
    iis_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    // derive mean and deviation, drive the result request
    iis_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
